### rtl/glyph_table_search_offset_top_defines.svh
// assertion macros used by the checker file
`ifndef GLYPH_TABLE_SEARCH_OFFSET_TOP_DEFINES_SVH
`define GLYPH_TABLE_SEARCH_OFFSET_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define GTSO_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define GTSO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// what must hold in the cycle after reset is seen
`define GTSO_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

### rtl/gtso_pkg.sv
// ----------------------------------------------------------------------------
// gtso_pkg
// Types, constants and helpers for the glyph table search and offset block.
// ----------------------------------------------------------------------------
package gtso_pkg;

  localparam int MAX_GLYPHS = 4096;
  localparam int LEVELS     = 6;
  localparam int TBL_AW     = $clog2(MAX_GLYPHS);
  localparam int CNT_W      = TBL_AW + 1;
  localparam int CP_W       = 16;
  localparam int QUERY_W    = 21;
  localparam int LVL_W      = 3;
  localparam int OFF_W      = 32;
  localparam int PACK_W     = 48;
  localparam int HLC_W      = 8;
  localparam int QUEUE_AW   = 1;

  localparam logic [OFF_W-1:0] HDR_FIXED_BYTES   = 32'd12;
  localparam logic [OFF_W-1:0] LEVEL_ENTRY_BYTES = 32'd4;
  localparam logic [OFF_W-1:0] ALIGN_MASK        = ~32'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PACK_W;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_LEVELS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDES  = 2'd3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] KIND_LOAD      = 2'd0;
  localparam logic [1:0] KIND_LOOKUP    = 2'd1;
  localparam logic [1:0] KIND_BAD_LEVEL = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [TBL_AW-1:0] entry_index;
    logic [CP_W-1:0]   entry_codepoint;
    logic [QUERY_W-1:0] codepoint;
    logic [LVL_W-1:0]  size_level;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] glyph_offset;
    logic [7:0]       cell_rows;
    logic [7:0]       row_bytes;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  glyph_count;
    logic [HLC_W-1:0]  header_level_count;
    logic [PACK_W-1:0] cell_sizes_packed;
    logic [PACK_W-1:0] row_strides_packed;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TBL_AW-1:0]  entry_index;
    logic [CP_W-1:0]    entry_codepoint;
    logic [QUERY_W-1:0] codepoint;
    logic [LVL_W-1:0]   level;
  } cmd_t;

  function automatic logic [7:0] level_byte(logic [PACK_W-1:0] packed_val,
                                            logic [LVL_W-1:0] lvl);
    logic [7:0] res;
    case (lvl)
      3'd0:    res = packed_val[7:0];
      3'd1:    res = packed_val[15:8];
      3'd2:    res = packed_val[23:16];
      3'd3:    res = packed_val[31:24];
      3'd4:    res = packed_val[39:32];
      3'd5:    res = packed_val[47:40];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

### rtl/gtso_front.sv
// ----------------------------------------------------------------------------
// gtso_front
// Takes requests and tags each as a table load, a lookup or a bad level.
// ----------------------------------------------------------------------------
module gtso_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  gtso_pkg::in_item_t in_data,
  output logic             q_push,
  input  logic             q_ready,
  output gtso_pkg::cmd_t   q_cmd
);

  logic level_ok;

  assign level_ok = (in_data.size_level < gtso_pkg::LVL_W'(gtso_pkg::LEVELS));

  assign in_ready = q_ready;
  assign q_push   = in_valid;

  always_comb begin
    q_cmd.entry_index     = in_data.entry_index;
    q_cmd.entry_codepoint = in_data.entry_codepoint;
    q_cmd.codepoint       = in_data.codepoint;
    q_cmd.level           = in_data.size_level;
    if (in_data.operation == gtso_pkg::OP_LOAD) begin
      q_cmd.kind = gtso_pkg::KIND_LOAD;
    end else if (level_ok) begin
      q_cmd.kind = gtso_pkg::KIND_LOOKUP;
    end else begin
      q_cmd.kind = gtso_pkg::KIND_BAD_LEVEL;
    end
  end

endmodule

### rtl/gtso_queue.sv
// ----------------------------------------------------------------------------
// gtso_queue
// Short request queue between the front and the search engine.
// ----------------------------------------------------------------------------
module gtso_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           push_ready,
  input  gtso_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gtso_pkg::cmd_t pop_cmd
);

  localparam int DEPTH = 1 << gtso_pkg::QUEUE_AW;

  gtso_pkg::cmd_t                  slot_r [DEPTH];
  logic [gtso_pkg::QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [gtso_pkg::QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [gtso_pkg::QUEUE_AW:0]     cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign push_ready = (cnt_r != (gtso_pkg::QUEUE_AW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/gtso_back.sv
// ----------------------------------------------------------------------------
// gtso_back
// Holds the codepoint table, runs the binary search and builds the offset.
// ----------------------------------------------------------------------------
module gtso_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gtso_pkg::cfg_t      cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  gtso_pkg::cmd_t      q_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output gtso_pkg::out_item_t out_data
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PROBE   = 3'd1;
  localparam logic [2:0] ST_CMP     = 3'd2;
  localparam logic [2:0] ST_LVL_MUL = 3'd3;
  localparam logic [2:0] ST_LVL_ACC = 3'd4;
  localparam logic [2:0] ST_IDX_ACC = 3'd5;
  localparam logic [2:0] ST_OUT     = 3'd6;

  localparam int AW = gtso_pkg::TBL_AW;
  localparam int CW = gtso_pkg::CNT_W;
  localparam int OW = gtso_pkg::OFF_W;

  logic [gtso_pkg::CP_W-1:0] tbl_mem [gtso_pkg::MAX_GLYPHS];

  logic [2:0]                  state_r, state_nxt;
  logic [gtso_pkg::QUERY_W-1:0] query_r, query_nxt;
  logic [gtso_pkg::LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [gtso_pkg::LVL_W-1:0]  lvl_i_r, lvl_i_nxt;
  logic [CW-1:0]               lo_r, lo_nxt;
  logic [CW-1:0]               hi_r, hi_nxt;   // exclusive upper bound
  logic [AW-1:0]               mid_r, mid_nxt;
  logic [gtso_pkg::CP_W-1:0]   rdata_r;
  logic [15:0]                 prod_r, prod_nxt;
  logic [OW-1:0]               acc_r, acc_nxt;
  gtso_pkg::out_item_t         res_r, res_nxt;

  logic          tbl_we, tbl_re;
  logic [CW-1:0] search_cnt;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_w;
  logic [OW-1:0] ds_raw, data_start;
  logic [28:0]   lvl_term;
  logic [27:0]   idx_term;
  logic [CW-1:0] cmp_lo, cmp_hi;
  logic          cmp_hit, cmp_below;

  assign q_ready   = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = res_r;

  assign search_cnt = (cfg.glyph_count > CW'(gtso_pkg::MAX_GLYPHS)) ?
                      CW'(gtso_pkg::MAX_GLYPHS) : cfg.glyph_count;

  // midpoint of the inclusive range [lo, hi-1]
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CW+1)'(1);
  assign mid_w   = mid_sum[AW:1];

  assign ds_raw = gtso_pkg::HDR_FIXED_BYTES
                + OW'(cfg.header_level_count) * gtso_pkg::LEVEL_ENTRY_BYTES
                + {{(OW-CW-1){1'b0}}, cfg.glyph_count, 1'b0};
  assign data_start = (ds_raw + OW'(3)) & gtso_pkg::ALIGN_MASK;

  assign lvl_term = cfg.glyph_count * prod_r;
  assign idx_term = mid_r * prod_r;

  assign cmp_hit   = (rdata_r == query_r[gtso_pkg::CP_W-1:0]);
  assign cmp_below = ({{(gtso_pkg::QUERY_W-gtso_pkg::CP_W){1'b0}}, rdata_r} < query_r);
  assign cmp_lo    = cmp_below ? {1'b0, mid_r} + CW'(1) : lo_r;
  assign cmp_hi    = cmp_below ? hi_r : {1'b0, mid_r};

  assign tbl_we = q_valid && q_ready && (q_cmd.kind == gtso_pkg::KIND_LOAD);
  assign tbl_re = (state_r == ST_PROBE);

  always_comb begin
    state_nxt = state_r;
    query_nxt = query_r;
    lvl_nxt   = lvl_r;
    lvl_i_nxt = lvl_i_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          res_nxt   = '0;
          query_nxt = q_cmd.codepoint;
          lvl_nxt   = q_cmd.level;
          lo_nxt    = '0;
          hi_nxt    = search_cnt;
          state_nxt = ST_OUT;
          if (q_cmd.kind == gtso_pkg::KIND_LOOKUP) begin
            res_nxt.cell_rows = gtso_pkg::level_byte(cfg.cell_sizes_packed, q_cmd.level);
            res_nxt.row_bytes = gtso_pkg::level_byte(cfg.row_strides_packed, q_cmd.level);
            if (search_cnt != '0) begin
              state_nxt = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        mid_nxt   = mid_w;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (cmp_hit) begin
          acc_nxt   = data_start;
          lvl_i_nxt = '0;
          state_nxt = ST_LVL_MUL;
        end else begin
          lo_nxt    = cmp_lo;
          hi_nxt    = cmp_hi;
          state_nxt = (cmp_lo < cmp_hi) ? ST_PROBE : ST_OUT;
        end
      end
      ST_LVL_MUL: begin
        // lower levels first, then the glyph's own level
        prod_nxt = gtso_pkg::level_byte(cfg.row_strides_packed, lvl_i_r)
                 * gtso_pkg::level_byte(cfg.cell_sizes_packed, lvl_i_r);
        state_nxt = (lvl_i_r == lvl_r) ? ST_IDX_ACC : ST_LVL_ACC;
      end
      ST_LVL_ACC: begin
        acc_nxt   = acc_r + {{(OW-29){1'b0}}, lvl_term};
        lvl_i_nxt = lvl_i_r + 1'b1;
        state_nxt = ST_LVL_MUL;
      end
      ST_IDX_ACC: begin
        res_nxt.found        = 1'b1;
        res_nxt.glyph_offset = acc_r + {{(OW-28){1'b0}}, idx_term};
        state_nxt            = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r <= query_nxt;
    lvl_r   <= lvl_nxt;
    lvl_i_r <= lvl_i_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[q_cmd.entry_index] <= q_cmd.entry_codepoint;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_re) begin
      rdata_r <= tbl_mem[mid_w];
    end
  end

endmodule

### rtl/glyph_table_search_offset_top.sv
// ----------------------------------------------------------------------------
// glyph_table_search_offset_top
// Sorted codepoint table with binary search and glyph bitmap offset.
// ----------------------------------------------------------------------------
// A load request writes its entry into the table. A lookup makes binary
// search probes (at most 13 for 4096 entries); on a hit it adds the sizes of
// the lower levels, then the glyph's offset within its own level, to the
// aligned data start. The search loop dominates, since each probe waits on the
// single registered read port of the table memory; a two-entry queue holds
// requests while the engine works. Configuration must be written only while
// the block is idle; the block itself does not enforce it.
module glyph_table_search_offset_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gtso_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gtso_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [gtso_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtso_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  gtso_pkg::cfg_t cfg_r;
  gtso_pkg::cmd_t front_cmd, queue_cmd;
  logic           front_push, queue_ready, queue_valid, back_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_count        <= '0;
      cfg_r.header_level_count <= gtso_pkg::HLC_W'(gtso_pkg::LEVELS);
      cfg_r.cell_sizes_packed  <= '0;
      cfg_r.row_strides_packed <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gtso_pkg::CFG_GLYPH_COUNT:
          cfg_r.glyph_count <= cfg_wdata[gtso_pkg::CNT_W-1:0];
        gtso_pkg::CFG_HDR_LEVELS:
          cfg_r.header_level_count <= cfg_wdata[gtso_pkg::HLC_W-1:0];
        gtso_pkg::CFG_CELL_SIZES:
          cfg_r.cell_sizes_packed <= cfg_wdata;
        gtso_pkg::CFG_ROW_STRIDES:
          cfg_r.row_strides_packed <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  gtso_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (front_push),
    .q_ready  (queue_ready),
    .q_cmd    (front_cmd)
  );

  gtso_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_push),
    .push_ready (queue_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (queue_cmd)
  );

  gtso_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (queue_valid),
    .q_ready   (back_ready),
    .q_cmd     (queue_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/gtso_checker.sv
// ----------------------------------------------------------------------------
// gtso_checker
// Port-level checks on the result channel and on the idle state after reset, bound to the top level.
// ----------------------------------------------------------------------------
`include "glyph_table_search_offset_top_defines.svh"

module gtso_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gtso_pkg::out_item_t out_data
);

  // a stalled result keeps its value
  `GTSO_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // no offset without a match
  `GTSO_ASSERT(a_miss_zero, out_valid && !out_data.found, out_data.glyph_offset == '0, "offset on a miss")

  // the engine goes back to idle after each result
  `GTSO_ASSERT_NXT(a_out_gap, out_valid && out_ready, !out_valid, "results back to back")

  `GTSO_ASSERT_RST(a_rst_idle, !out_valid && in_ready, "not idle after reset")

endmodule

bind glyph_table_search_offset_top gtso_checker u_gtso_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
